// ===== rtl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, byte codes and class helpers for the script token splitter.
// ----------------------------------------------------------------------------
package stsc_pkg;

    // longest line in bytes, saturation points follow from it
    localparam int LINE_BYTES = 4096;

    localparam int POS_MAX_I   = (LINE_BYTES < 8191) ? LINE_BYTES : 8191;
    localparam int LEN_MAX_I   = (LINE_BYTES < 4096) ? LINE_BYTES : 4096;
    localparam int START_MAX_I = ((LINE_BYTES - 1) < 4095) ? (LINE_BYTES - 1) : 4095;

    localparam logic [12:0] POS_MAX   = 13'(POS_MAX_I);
    localparam logic [12:0] LEN_MAX   = 13'(LEN_MAX_I);
    localparam logic [12:0] START_MAX = 13'(START_MAX_I);

    // byte codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        SM_SEEK    = 2'd0,
        SM_SPACE   = 2'd1,
        SM_STRING  = 2'd2,
        SM_COMMENT = 2'd3
    } t_split_mode;

    typedef enum logic [2:0] {
        CM_START   = 3'd0,
        CM_FLOAT   = 3'd1,
        CM_DOT     = 3'd2,
        CM_POSTDOT = 3'd3,
        CM_STRING  = 3'd4,
        CM_WORD    = 3'd5
    } t_class_mode;

    typedef enum logic [2:0] {
        CLS_FLOAT  = 3'd0,
        CLS_STRING = 3'd1,
        CLS_WORD   = 3'd2,
        CLS_IGNORE = 3'd3,
        CLS_ERROR  = 3'd4
    } t_token_class;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in_beat;

    typedef struct packed {
        t_token_class token_class;
        logic [11:0]  token_start;
        logic [12:0]  token_length;
        logic         last_token;
    } t_out_beat;

    typedef struct packed {
        t_class_mode mode;
        logic        err;
    } t_cls_state;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // advance the class tracker by one byte of the token
    function automatic t_cls_state classify(t_cls_state s, logic [7:0] c);
        t_cls_state r;
        r = s;
        if (!s.err) begin
            case (s.mode)
                CM_START: begin
                    if ((c == CH_MINUS) || is_digit(c)) r.mode = CM_FLOAT;
                    else if (c == CH_QUOTE)            r.mode = CM_STRING;
                    else                               r.mode = CM_WORD;
                end
                CM_FLOAT: begin
                    if (c == CH_DOT)       r.mode = CM_DOT;
                    else if (!is_digit(c)) r.err  = 1'b1;
                end
                CM_DOT, CM_POSTDOT: begin
                    if (is_digit(c)) r.mode = CM_POSTDOT;
                    else             r.err  = 1'b1;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // final class of a collected token
    function automatic t_token_class class_of(t_cls_state s);
        t_token_class k;
        if (s.err) begin
            k = CLS_ERROR;
        end else begin
            case (s.mode)
                CM_FLOAT, CM_DOT, CM_POSTDOT: k = CLS_FLOAT;
                CM_STRING:                    k = CLS_STRING;
                CM_WORD:                      k = CLS_WORD;
                default:                      k = CLS_IGNORE;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== rtl/stsc_if.sv =====
// ----------------------------------------------------------------------------
// stsc_in_if / stsc_out_if
// Valid/ready channels for byte beats and token beats.
// ----------------------------------------------------------------------------
interface stsc_in_if
    import stsc_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stsc_out_if
    import stsc_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/script_token_splitter_classifier_core.sv =====
// A token beat is registered into the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle; the byte is held off only while the
//   four-entry result queue has fewer than two free slots (output stalled).
// A byte yields zero, one or two token beats; the queue drains one per cycle while the output is ready.
// Reset: synchronous, active low; clears the split state and empties the queue.
// ----------------------------------------------------------------------------
// script_token_splitter_classifier_core
// Splits a script line into tokens and classes each one as it streams past.
// ----------------------------------------------------------------------------
module script_token_splitter_classifier_core
    import stsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    stsc_in_if.sink     i_in_ch,
    stsc_out_if.source  o_out_ch
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // split and class state
    t_split_mode  r_split, n_split;
    t_cls_state   r_cls,   n_cls;
    logic [11:0]  r_start, n_start;
    logic [12:0]  r_len,   n_len;
    logic [12:0]  r_pos,   n_pos;

    // result queue
    t_out_beat        r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt, n_cnt;

    logic       in_acc, out_acc;
    logic [1:0] n_res;
    t_out_beat  res0, res1;

    logic [7:0] c;
    logic       eol;
    logic       emit_first;

    assign c       = i_in_ch.data.char_in;
    assign eol     = i_in_ch.data.line_end;
    assign in_acc  = i_in_ch.valid && i_in_ch.ready;
    assign out_acc = o_out_ch.valid && o_out_ch.ready;

    assign i_in_ch.ready  = (r_cnt <= (QAW+1)'(QDEPTH - 2));
    assign o_out_ch.valid = (r_cnt != '0);
    assign o_out_ch.data  = r_q[r_rp];

    // one byte through the splitter
    always_comb begin
        t_split_mode sm1;
        t_cls_state  cs1;
        logic [11:0] st1;
        logic [12:0] ln1;
        t_out_beat   e0, e1;
        logic        take;

        emit_first = (r_split == SM_SPACE) && (c != CH_SPACE);

        e0.token_class  = class_of(r_cls);
        e0.token_start  = r_start;
        e0.token_length = r_len;
        e0.last_token   = 1'b0;

        // a non-space after spaces or a closing quote closes the previous token
        if (emit_first) begin
            sm1 = SM_SEEK;
            cs1 = '{CM_START, 1'b0};
            ln1 = '0;
            st1 = (r_pos < START_MAX) ? r_pos[11:0] : START_MAX[11:0];
        end else begin
            sm1 = r_split;
            cs1 = r_cls;
            ln1 = r_len;
            st1 = r_start;
        end

        n_split = sm1;
        take    = 1'b0;
        unique case (sm1)
            SM_SEEK: begin
                priority if (c == CH_SPACE) begin
                    n_split = SM_SPACE;
                end else if (c == CH_QUOTE) begin
                    n_split = SM_STRING;
                    take    = 1'b1;
                end else if (c == CH_HASH) begin
                    n_split = SM_COMMENT;
                end else begin
                    take = 1'b1;
                end
            end
            SM_STRING: begin
                if (c == CH_QUOTE) n_split = SM_SPACE;
                take = 1'b1;
            end
            SM_SPACE, SM_COMMENT: ;
        endcase

        if (take) begin
            n_cls = classify(cs1, c);
            n_len = (ln1 < LEN_MAX) ? ln1 + 13'd1 : ln1;
        end else begin
            n_cls = cs1;
            n_len = ln1;
        end
        n_start = st1;
        n_pos   = (r_pos < POS_MAX) ? r_pos + 13'd1 : r_pos;

        e1.token_class  = class_of(n_cls);
        e1.token_start  = st1;
        e1.token_length = n_len;
        e1.last_token   = 1'b1;

        // line end returns the split state to its reset value
        if (eol) begin
            n_split = SM_SEEK;
            n_cls   = '{CM_START, 1'b0};
            n_len   = '0;
            n_start = '0;
            n_pos   = '0;
        end

        res0  = emit_first ? e0 : e1;
        res1  = e1;
        n_res = {1'b0, emit_first} + {1'b0, eol};
    end

    // queue occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc)  n_cnt = n_cnt + {{(QAW-1){1'b0}}, n_res};
        if (out_acc) n_cnt = n_cnt - (QAW+1)'(1);
    end

    // state and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= SM_SEEK;
            r_cls   <= '{CM_START, 1'b0};
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_acc) begin
                r_split <= n_split;
                r_cls   <= n_cls;
                r_start <= n_start;
                r_len   <= n_len;
                r_pos   <= n_pos;
                r_wp    <= r_wp + QAW'(n_res);
            end
            if (out_acc) r_rp <= r_rp + QAW'(1);
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && (n_res != 2'd0)) r_q[r_wp]            <= res0;
        if (in_acc && (n_res == 2'd2)) r_q[r_wp + QAW'(1)] <= res1;
    end

    // queue never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("result queue over capacity");

    // a line end leaves the splitter in its reset state
    a_eol_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eol) |=> (r_split == SM_SEEK && r_len == '0 && r_pos == '0
                             && r_start == '0 && r_cls.mode == CM_START && !r_cls.err))
        else $error("state not cleared after line end");

    // a byte ending a line always leaves a token in the queue next cycle
    a_eol_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eol) |=> o_out_ch.valid)
        else $error("line end produced no token");

    // token length never passes its saturation point
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("token length beyond saturation");

endmodule
